// ===== hdl/blsr_pkg.sv =====
// Shared types and constants for the backlight level step ramp.
// Holds the controller state, command and status types and the table lookup.
// Depends on nothing; the top level, controller and datapath use it by scoped names.
package blsr_pkg;

    // Level and table constants.
    localparam logic [6:0]  FULL_LEVEL      = 7'd100;
    localparam logic [2:0]  MAX_STEPS       = 3'd4;
    localparam logic [15:0] TICK_PERIOD_RST = 16'd10;

    // Magnitude of delta times a proportion: 7 bits by 16 bits.
    localparam int unsigned DIV_BITS  = 23;
    localparam int unsigned DIV_CNT_W = $clog2(DIV_BITS);

    // Item operation codes.
    typedef enum logic {
        OP_TICK   = 1'b0,
        OP_TARGET = 1'b1
    } t_op;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        CFG_STEP_COUNT = 2'd0,
        CFG_PROPORTION = 2'd1,
        CFG_STEP_WAIT  = 2'd2,
        CFG_TICK       = 2'd3
    } t_cfg_idx;

    // Controller states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_EVAL,
        S_DIV,
        S_APPLY,
        S_PUSH
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic eval;
        logic div_step;
        logic apply;
        logic push;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic need_div;
        logic div_last;
        logic out_free;
    } t_status;

    // One 16-bit entry of a packed four-entry table; the top entry has 15 bits.
    function automatic logic [15:0] f_entry(input logic [62:0] tbl, input logic [1:0] idx);
        logic [15:0] v;
        unique case (idx)
            2'd0:    v = tbl[15:0];
            2'd1:    v = tbl[31:16];
            2'd2:    v = tbl[47:32];
            default: v = {1'b0, tbl[62:48]};
        endcase
        return v;
    endfunction

endpackage

// ===== hdl/backlight_level_step_ramp_top.sv =====
// One channel of a backlight level ramp. Each input word is either a tick or
// a new target and gives exactly one output word with the level and the
// ramping flag. A tick that takes a ramp step goes through capture,
// evaluation with the product register, the one-bit-per-cycle restoring
// divider, the step apply and the push into the output register. Every
// other word goes through capture, evaluation and the push. One word is
// worked on at a time; the next word is accepted while the previous result
// still waits in the output register. Configuration is written through a
// plain write port. Depends on blsr_pkg, blsr_ctrl and blsr_dp.
module backlight_level_step_ramp_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [62:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_operation,
    input  logic [6:0]  i_target_level,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [6:0]  o_level,
    output logic        o_ramping
);

    blsr_pkg::t_cmd    w_cmd;
    blsr_pkg::t_status w_status;

    // Controller.
    blsr_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_status (w_status),
        .o_cmd    (w_cmd)
    );

    // Datapath.
    blsr_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_operation    (i_operation),
        .i_target_level (i_target_level),
        .i_ready        (i_ready),
        .o_valid        (o_valid),
        .o_level        (o_level),
        .o_ramping      (o_ramping),
        .i_cmd          (w_cmd),
        .o_status       (w_status)
    );

endmodule

// ===== hdl/blsr_ctrl.sv =====
// Controller state machine of the backlight level step ramp.
// Sequences capture, evaluation, division, step apply and result push.
// Depends on blsr_pkg.
module blsr_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  blsr_pkg::t_status i_status,
    output blsr_pkg::t_cmd    o_cmd
);

    blsr_pkg::t_state r_state;
    blsr_pkg::t_state n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= blsr_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            blsr_pkg::S_IDLE: begin
                if (i_valid) n_state = blsr_pkg::S_EVAL;
            end
            blsr_pkg::S_EVAL: begin
                n_state = i_status.need_div ? blsr_pkg::S_DIV : blsr_pkg::S_PUSH;
            end
            blsr_pkg::S_DIV: begin
                if (i_status.div_last) n_state = blsr_pkg::S_APPLY;
            end
            blsr_pkg::S_APPLY: begin
                n_state = blsr_pkg::S_PUSH;
            end
            blsr_pkg::S_PUSH: begin
                if (i_status.out_free) n_state = blsr_pkg::S_IDLE;
            end
            default: n_state = blsr_pkg::S_IDLE;
        endcase
    end

    // Outputs: commands and the input ready.
    always_comb begin
        o_cmd   = '0;
        o_ready = 1'b0;
        unique case (r_state)
            blsr_pkg::S_IDLE: begin
                o_ready     = 1'b1;
                o_cmd.capture = i_valid;
            end
            blsr_pkg::S_EVAL:  o_cmd.eval     = 1'b1;
            blsr_pkg::S_DIV:   o_cmd.div_step = 1'b1;
            blsr_pkg::S_APPLY: o_cmd.apply    = 1'b1;
            blsr_pkg::S_PUSH:  o_cmd.push     = i_status.out_free;
            default: o_cmd = '0;
        endcase
    end

endmodule

// ===== hdl/blsr_dp.sv =====
// Datapath of the backlight level step ramp: configuration, ramp state,
// product register, restoring divider and the output word register.
// Depends on blsr_pkg.
module blsr_dp (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [1:0]        i_cfg_index,
    input  logic [62:0]       i_cfg_data,
    input  logic              i_operation,
    input  logic [6:0]        i_target_level,
    input  logic              i_ready,
    output logic              o_valid,
    output logic [6:0]        o_level,
    output logic              o_ramping,
    input  blsr_pkg::t_cmd    i_cmd,
    output blsr_pkg::t_status o_status
);

    localparam int unsigned QW = blsr_pkg::DIV_BITS;

    // Configuration registers.
    logic [2:0]  r_step_count;
    logic [62:0] r_prop_tbl;
    logic [62:0] r_wait_tbl;
    logic [15:0] r_tick_period;

    // Captured word.
    blsr_pkg::t_op r_op;
    logic [6:0]    r_tgt;

    // Ramp state.
    logic [6:0]        r_base;
    logic [6:0]        r_out;
    logic signed [7:0] r_delta;
    logic              r_busy;
    logic [2:0]        r_step_idx;
    logic [15:0]       r_wait;

    // Divider.
    logic [QW-1:0]                    r_quo;
    logic [15:0]                      r_rem;
    logic [15:0]                      r_den;
    logic                             r_neg;
    logic [blsr_pkg::DIV_CNT_W-1:0]   r_div_cnt;

    // Output word register.
    logic       r_o_valid;
    logic [6:0] r_o_level;
    logic       r_o_ramping;

    logic [2:0]  w_n;
    logic [2:0]  w_last;
    logic [15:0] w_sum;
    logic        w_idle_clear;
    logic        w_abandon;
    logic        w_step;
    logic [7:0]  w_abs;
    logic [QW-1:0] w_prod;
    logic [15:0] w_per;
    logic [15:0] w_wait_next;
    logic [6:0]  w_t;
    logic        w_start;
    logic [7:0]  w_new_delta;
    logic [16:0] w_trial;
    logic        w_ge;
    logic [16:0] w_rem_next;
    logic [QW:0] w_up;
    logic [6:0]  w_step_level;
    logic [2:0]  w_next_idx;
    logic [15:0] w_next_wait;
    logic        w_out_free;

    // Steps in use, the last proportion and the tick decision.
    always_comb begin
        w_n          = (r_step_count > blsr_pkg::MAX_STEPS) ? blsr_pkg::MAX_STEPS : r_step_count;
        w_last       = w_n - 3'd1;
        w_sum        = blsr_pkg::f_entry(r_prop_tbl, w_last[1:0]);
        w_idle_clear = (w_n == 3'd0) || (r_step_idx >= w_n);
        w_abandon    = !w_idle_clear && ((r_delta == 8'sd0) || (w_sum == 16'd0));
        w_step       = !w_idle_clear && !w_abandon && (r_wait == 16'd0);
    end

    // Product magnitude of the delta and the current proportion.
    always_comb begin
        w_abs  = r_delta[7] ? (8'd0 - r_delta) : r_delta;
        w_prod = QW'(w_abs[6:0]) * QW'(blsr_pkg::f_entry(r_prop_tbl, r_step_idx[1:0]));
    end

    // Saturating countdown; a zero period counts as one.
    always_comb begin
        w_per       = (r_tick_period == 16'd0) ? 16'd1 : r_tick_period;
        w_wait_next = (r_wait > w_per) ? (r_wait - w_per) : 16'd0;
    end

    // Target clamp and ramp start decision.
    always_comb begin
        w_t         = (r_tgt > blsr_pkg::FULL_LEVEL) ? blsr_pkg::FULL_LEVEL : r_tgt;
        w_start     = !r_busy && (w_t != r_base) && (w_n != 3'd0);
        w_new_delta = {1'b0, w_t} - {1'b0, r_base};
    end

    // One restoring division step.
    always_comb begin
        w_trial    = {r_rem, r_quo[QW-1]};
        w_ge       = (w_trial >= {1'b0, r_den});
        w_rem_next = w_ge ? (w_trial - {1'b0, r_den}) : w_trial;
    end

    // Step level from the quotient, clamped to the valid range.
    always_comb begin
        w_up = (QW+1)'(r_base) + (QW+1)'(r_quo);
        if (r_neg) begin
            w_step_level = (r_quo >= QW'(r_base)) ? 7'd0 : (r_base - r_quo[6:0]);
        end else begin
            w_step_level = (w_up > (QW+1)'(blsr_pkg::FULL_LEVEL)) ?
                           blsr_pkg::FULL_LEVEL : w_up[6:0];
        end
        w_next_idx  = r_step_idx + 3'd1;
        w_next_wait = (w_next_idx < w_n) ?
                      blsr_pkg::f_entry(r_wait_tbl, w_next_idx[1:0]) : 16'd0;
    end

    assign w_out_free = !r_o_valid || i_ready;

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step_count  <= 3'd0;
            r_prop_tbl    <= '0;
            r_wait_tbl    <= '0;
            r_tick_period <= blsr_pkg::TICK_PERIOD_RST;
        end else if (i_cfg_we) begin
            unique case (blsr_pkg::t_cfg_idx'(i_cfg_index))
                blsr_pkg::CFG_STEP_COUNT: r_step_count  <= i_cfg_data[2:0];
                blsr_pkg::CFG_PROPORTION: r_prop_tbl    <= i_cfg_data;
                blsr_pkg::CFG_STEP_WAIT:  r_wait_tbl    <= i_cfg_data;
                blsr_pkg::CFG_TICK:       r_tick_period <= i_cfg_data[15:0];
                default: r_step_count <= r_step_count;
            endcase
        end
    end

    // Captured input word.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op  <= blsr_pkg::t_op'(i_operation);
            r_tgt <= i_target_level;
        end
    end

    // Ramp state updates.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base     <= blsr_pkg::FULL_LEVEL;
            r_out      <= blsr_pkg::FULL_LEVEL;
            r_delta    <= 8'sd0;
            r_busy     <= 1'b0;
            r_step_idx <= 3'd0;
            r_wait     <= 16'd0;
        end else if (i_cmd.eval) begin
            if (r_op == blsr_pkg::OP_TARGET) begin
                if (w_start) begin
                    r_busy  <= 1'b1;
                    r_delta <= w_new_delta;
                end else begin
                    r_out <= w_t;
                end
            end else if (w_idle_clear || w_abandon) begin
                r_delta    <= 8'sd0;
                r_busy     <= 1'b0;
                r_step_idx <= 3'd0;
                r_wait     <= 16'd0;
                if (w_idle_clear) r_base <= r_out;
            end else if (!w_step) begin
                r_wait <= w_wait_next;
            end
        end else if (i_cmd.apply) begin
            r_out      <= w_step_level;
            r_step_idx <= w_next_idx;
            r_wait     <= w_next_wait;
        end
    end

    // Divider: load the product, then one quotient bit per cycle.
    always_ff @(posedge i_clk) begin
        if (i_cmd.eval) begin
            r_quo     <= w_prod;
            r_rem     <= 16'd0;
            r_den     <= w_sum;
            r_neg     <= r_delta[7];
            r_div_cnt <= '0;
        end else if (i_cmd.div_step) begin
            r_quo     <= {r_quo[QW-2:0], w_ge};
            r_rem     <= w_rem_next[15:0];
            r_div_cnt <= r_div_cnt + 1'b1;
        end
    end

    // Output word register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (i_cmd.push) begin
            r_o_valid <= 1'b1;
        end else if (i_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_o_level   <= r_out;
            r_o_ramping <= r_busy;
        end
    end

    assign o_valid   = r_o_valid;
    assign o_level   = r_o_level;
    assign o_ramping = r_o_ramping;

    assign o_status.need_div = (r_op == blsr_pkg::OP_TICK) && w_step;
    assign o_status.div_last = (r_div_cnt == blsr_pkg::DIV_CNT_W'(QW - 1));
    assign o_status.out_free = w_out_free;

endmodule

// ===== hdl/blsr_checker.sv =====
// Port-level checks for the backlight level step ramp top level.
// Watches the channel handshakes and output range; bound to the top level.
// Depends only on the top level's ports.
module blsr_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_ready,
    input logic        o_valid,
    input logic        i_ready,
    input logic [6:0]  o_level,
    input logic        o_ramping
);

    // A stalled output word holds its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_level) && $stable(o_ramping)))
        else $error("output word changed while stalled");

    // The level never leaves the percent range.
    a_level_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_level <= 7'd100))
        else $error("output level above full scale");

    // One word at a time: after an accept the input side closes.
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("second word accepted while one is in work");

    // Reset empties the output register.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

endmodule

bind backlight_level_step_ramp_top blsr_checker u_blsr_checker (.*);
